[src/tsm_pkg.sv]
// shared types, codes and defaults of the timestamp stream merge
`default_nettype none

package tsm_pkg;

  // default configuration
  localparam int unsigned STREAMS_DEF = 4;
  localparam int unsigned DEPTH_DEF   = 256;

  // item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_DROP  = 2'd2;

  // one stored entry: timestamp in the high half, tag in the low half
  typedef struct packed {
    logic signed [31:0] ts;
    logic [31:0]        tag;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // per-stream control from the merge stage
  typedef struct packed {
    logic load;
    logic pop;
  } stream_ctl_t;

  // per-stream status toward the merge stage
  typedef struct packed {
    logic   nonempty;
    logic   full;
    entry_t head;
  } stream_stat_t;

endpackage

`default_nettype wire

[src/timestamp_stream_merge.sv]
// k-way merge of per-stream entry queues in timestamp order
//
// Item channel (item_valid_i / item_stall_o) carries one beat per load or pop:
// func_i selects load or pop, stream_sel_i and time_stamp_i / entry_tag_i
// describe a load. Result channel (res_valid_o / res_stall_i) returns exactly
// one beat per item: status_o, and for a successful pop out_valid_o together
// with out_stream_o, out_time_o and out_tag_o.
// A beat taken sits in the input register; its result is loaded into the
// result register once that register is free, so a receiver stall delays it.
// Throughput is one item per cycle while the receiver does not stall: every
// stream keeps its head entry in a register and prefetches the next one from
// its memory, and a pop runs a single pass through the head comparator tree
// into the result register.
// Reset clears the fill counts and read positions of all streams; the entry
// memories hold no reset value.
// While the receiver stalls, the result register holds its beat, the input
// register holds one more item, and then item_stall_o is raised.
`default_nettype none

module timestamp_stream_merge #(
  parameter int unsigned STREAMS = tsm_pkg::STREAMS_DEF,
  parameter int unsigned DEPTH   = tsm_pkg::DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_stall_o,
  input  logic               func_i,
  input  logic [1:0]         stream_sel_i,
  input  logic signed [31:0] time_stamp_i,
  input  logic [31:0]        entry_tag_i,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output logic [1:0]         status_o,
  output logic               out_valid_o,
  output logic [1:0]         out_stream_o,
  output logic signed [31:0] out_time_o,
  output logic [31:0]        out_tag_o
);

  import tsm_pkg::*;

  localparam int unsigned SW = $clog2(STREAMS);

  logic          in_acc, res_free, proc;
  logic          s1_vld_q, s1_vld_d;
  logic          s1_func_q;
  logic [1:0]    s1_sel_q;
  entry_t        s1_entry_q;
  logic          sel_ok;
  logic [SW-1:0] sel_idx;
  logic          sel_full;
  logic          found;
  logic [SW-1:0] best;
  logic          do_load, do_pop;

  stream_ctl_t        ctl  [STREAMS];
  stream_stat_t       stat [STREAMS];
  logic [STREAMS-1:0] head_vld;
  logic signed [31:0] head_ts [STREAMS];
  logic [STREAMS-1:0] load_vec, pop_vec;

  logic          res_vld_q, res_vld_d;
  logic [1:0]    res_status_q, res_status_d;
  logic          res_hit_q, res_hit_d;
  logic [1:0]    res_stream_q, res_stream_d;
  entry_t        res_entry_q, res_entry_d;

  // handshake between input register and result register
  assign res_free     = !res_vld_q || !res_stall_i;
  assign proc         = s1_vld_q && res_free;
  assign item_stall_o = s1_vld_q && !res_free;
  assign in_acc       = item_valid_i && !item_stall_o;

  assign s1_vld_d  = in_acc ? 1'b1 : (proc ? 1'b0 : s1_vld_q);
  assign res_vld_d = proc ? 1'b1 : (res_stall_i ? res_vld_q : 1'b0);

  // load target decode
  assign sel_ok   = 32'(s1_sel_q) < 32'(STREAMS);
  assign sel_idx  = SW'(s1_sel_q);
  assign sel_full = sel_ok && stat[sel_idx].full;
  assign do_load  = proc && (s1_func_q == FUNC_LOAD) && sel_ok && !sel_full;
  assign do_pop   = proc && (s1_func_q == FUNC_POP) && found;

  // stream queues
  for (genvar g = 0; g < STREAMS; g++) begin : g_stream
    assign load_vec[g] = do_load && (sel_idx == SW'(g));
    assign pop_vec[g]  = do_pop && (best == SW'(g));
    assign ctl[g].load = load_vec[g];
    assign ctl[g].pop  = pop_vec[g];
    assign head_vld[g] = stat[g].nonempty;
    assign head_ts[g]  = stat[g].head.ts;

    tsm_stream #(
      .DEPTH (DEPTH)
    ) u_stream (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[g]),
      .wdata_i (s1_entry_q),
      .stat_o  (stat[g])
    );
  end

  // earliest head across streams
  tsm_min_tree #(
    .N (STREAMS)
  ) u_min_tree (
    .vld_i   (head_vld),
    .key_i   (head_ts),
    .found_o (found),
    .idx_o   (best)
  );

  // result formation
  always_comb begin
    res_status_d = STATUS_OK;
    res_hit_d    = 1'b0;
    res_stream_d = '0;
    res_entry_d  = '0;
    if (s1_func_q == FUNC_LOAD) begin
      if (!sel_ok || sel_full) begin
        res_status_d = STATUS_DROP;
      end
    end else if (found) begin
      res_hit_d    = 1'b1;
      res_stream_d = 2'(best);
      res_entry_d  = stat[best].head;
    end else begin
      res_status_d = STATUS_EMPTY;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q      <= func_i;
      s1_sel_q       <= stream_sel_i;
      s1_entry_q.ts  <= time_stamp_i;
      s1_entry_q.tag <= entry_tag_i;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_status_q <= res_status_d;
      res_hit_q    <= res_hit_d;
      res_stream_q <= res_stream_d;
      res_entry_q  <= res_entry_d;
    end
  end

  assign res_valid_o  = res_vld_q;
  assign status_o     = res_status_q;
  assign out_valid_o  = res_hit_q;
  assign out_stream_o = res_stream_q;
  assign out_time_o   = res_entry_q.ts;
  assign out_tag_o    = res_entry_q.tag;

  // at most one stream advances per beat
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(pop_vec))
    else $error("more than one stream popped");

  // a beat either loads or pops, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((|load_vec) && (|pop_vec)))
    else $error("load and pop in the same beat");

  // the chosen stream really holds an unread entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |-> stat[best].nonempty)
    else $error("merge picked an exhausted stream");

  // a delivered entry always carries ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && out_valid_o) |-> (status_o == STATUS_OK))
    else $error("popped entry with error status");

endmodule

`default_nettype wire

[src/tsm_ram.sv]
// generic single-write, single-read memory with registered read data
`default_nettype none

module tsm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[src/tsm_stream.sv]
// one append-only stream queue with a head register and next-entry prefetch
`default_nettype none

module tsm_stream #(
  parameter int unsigned DEPTH = tsm_pkg::DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tsm_pkg::stream_ctl_t  ctl_i,
  input  tsm_pkg::entry_t       wdata_i,
  output tsm_pkg::stream_stat_t stat_o
);

  import tsm_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] rd_q, rd_d;
  logic [CW-1:0] rd_next;
  logic [AW-1:0] waddr, raddr;
  logic          nonempty, full;
  logic          byp_q, byp_d;
  entry_t        byp_data_q;
  entry_t        head_q, head_d;
  entry_t        next_entry;
  logic [ENTRY_W-1:0] rdata;

  // occupancy
  assign nonempty = rd_q < fill_q;
  assign full     = fill_q == CW'(DEPTH);

  assign fill_d  = fill_q + CW'(ctl_i.load);
  assign rd_d    = rd_q + CW'(ctl_i.pop);
  assign rd_next = rd_d + CW'(1);

  // write at the fill position, prefetch the entry after next cycle's head
  assign waddr = fill_q[AW-1:0];
  assign raddr = rd_next[AW-1:0];
  assign byp_d = ctl_i.load && (waddr == raddr);

  tsm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.load),
    .waddr_i (waddr),
    .wdata_i (wdata_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // a write to the prefetch address in the same cycle wins over the ram
  assign next_entry = byp_q ? byp_data_q : entry_t'(rdata);

  // head register update
  always_comb begin
    head_d = head_q;
    if (ctl_i.load && !nonempty) begin
      head_d = wdata_i;
    end else if (ctl_i.pop) begin
      head_d = next_entry;
    end
  end

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rd_q   <= '0;
      byp_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      rd_q   <= rd_d;
      byp_q  <= byp_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata_i;
    head_q     <= head_d;
  end

  assign stat_o.nonempty = nonempty;
  assign stat_o.full     = full;
  assign stat_o.head     = head_q;

  // read position never passes the fill count
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_q <= fill_q)
    else $error("read position beyond fill count");

  // fill count bounded by the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= CW'(DEPTH))
    else $error("fill count beyond depth");

  // pops only hit a stream with unread entries
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctl_i.pop |-> nonempty)
    else $error("pop from exhausted stream");

  // loads only reach a stream with room
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctl_i.load |-> !full)
    else $error("load into full stream");

endmodule

`default_nettype wire

[src/tsm_min_tree.sv]
// comparator tree picking the smallest valid timestamp, ties to the lowest index
`default_nettype none

module tsm_min_tree #(
  parameter int unsigned N = tsm_pkg::STREAMS_DEF,
  localparam int unsigned IW = $clog2(N)
) (
  input  logic [N-1:0]       vld_i,
  input  logic signed [31:0] key_i [N],
  output logic               found_o,
  output logic [IW-1:0]      idx_o
);

  localparam int unsigned LV = IW;
  localparam int unsigned P  = 1 << LV;

  logic               lv_vld [LV+1][P];
  logic [IW-1:0]      lv_idx [LV+1][P];
  logic signed [31:0] lv_key [LV+1][P];

  // tree of pairwise compares, left side holds the lower indices
  always_comb begin
    logic take;
    take = 1'b0;
    for (int l = 0; l <= LV; l++) begin
      for (int i = 0; i < P; i++) begin
        lv_vld[l][i] = 1'b0;
        lv_idx[l][i] = '0;
        lv_key[l][i] = '0;
      end
    end
    for (int i = 0; i < N; i++) begin
      lv_vld[0][i] = vld_i[i];
      lv_idx[0][i] = IW'(i);
      lv_key[0][i] = key_i[i];
    end
    for (int l = 0; l < LV; l++) begin
      for (int i = 0; i < P / 2; i++) begin
        if (i < (P >> (l + 1))) begin
          take = lv_vld[l][2*i+1] &&
                 (!lv_vld[l][2*i] || (lv_key[l][2*i+1] < lv_key[l][2*i]));
          lv_vld[l+1][i] = lv_vld[l][2*i] || lv_vld[l][2*i+1];
          lv_idx[l+1][i] = take ? lv_idx[l][2*i+1] : lv_idx[l][2*i];
          lv_key[l+1][i] = take ? lv_key[l][2*i+1] : lv_key[l][2*i];
        end
      end
    end
  end

  assign found_o = lv_vld[LV][0];
  assign idx_o   = lv_idx[LV][0];

endmodule

`default_nettype wire
